// ----- rtl/core/cswc_pkg.sv -----
// Shared widths, codes and control types of the complex strided window correlator.
package cswc_pkg;

   localparam int ACC_W      = 39;
   localparam int TAP_CNT_W  = 7;
   localparam int STRIDE_W   = 8;
   localparam int COEF_IDX_W = 6;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 8;

   localparam logic REQ_COEF   = 1'b0;
   localparam logic REQ_SAMPLE = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_TAP_COUNT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_STRIDE    = 1'b1;

   typedef struct packed {
      logic valid;
      logic first;
      logic last;
   } mac_ctrl_type;

endpackage

// ----- rtl/core/cswc_cmac.sv -----
// Shared complex multiply-accumulate unit: registered products, then a 39-bit accumulator.
module cswc_cmac #(
   parameter int SAMPLE_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  cswc_pkg::mac_ctrl_type               op_ctrl,
   input  logic signed [SAMPLE_BITS-1:0]        op_samp_re,
   input  logic signed [SAMPLE_BITS-1:0]        op_samp_im,
   input  logic signed [SAMPLE_BITS-1:0]        op_coef_re,
   input  logic signed [SAMPLE_BITS-1:0]        op_coef_im,
   output logic signed [cswc_pkg::ACC_W-1:0]    acc_re,
   output logic signed [cswc_pkg::ACC_W-1:0]    acc_im,
   output logic                                 done
);

   localparam int PROD_W = 2 * SAMPLE_BITS;
   localparam int EXT_W  = (PROD_W > cswc_pkg::ACC_W) ? PROD_W : cswc_pkg::ACC_W;

   cswc_pkg::mac_ctrl_type            pctl_ff;
   logic signed [PROD_W-1:0]          p_rr_ff, p_ii_ff, p_ri_ff, p_ir_ff;
   logic signed [PROD_W-1:0]          p_rr_in, p_ii_in, p_ri_in, p_ir_in;
   logic signed [cswc_pkg::ACC_W-1:0] acc_re_ff, acc_im_ff, acc_re_in, acc_im_in;
   logic                              done_ff;

   logic signed [EXT_W-1:0]           x_rr, x_ii, x_ri, x_ir;
   logic signed [cswc_pkg::ACC_W-1:0] t_re, t_im, base_re, base_im;

   always_comb begin
      p_rr_in = PROD_W'(op_samp_re) * PROD_W'(op_coef_re);
      p_ii_in = PROD_W'(op_samp_im) * PROD_W'(op_coef_im);
      p_ri_in = PROD_W'(op_samp_re) * PROD_W'(op_coef_im);
      p_ir_in = PROD_W'(op_samp_im) * PROD_W'(op_coef_re);
   end

   always_comb begin
      x_rr    = EXT_W'(p_rr_ff);
      x_ii    = EXT_W'(p_ii_ff);
      x_ri    = EXT_W'(p_ri_ff);
      x_ir    = EXT_W'(p_ir_ff);
      t_re    = x_rr[cswc_pkg::ACC_W-1:0] - x_ii[cswc_pkg::ACC_W-1:0];
      t_im    = x_ri[cswc_pkg::ACC_W-1:0] + x_ir[cswc_pkg::ACC_W-1:0];
      base_re = pctl_ff.first ? '0 : acc_re_ff;
      base_im = pctl_ff.first ? '0 : acc_im_ff;
      acc_re_in = acc_re_ff;
      acc_im_in = acc_im_ff;
      if (pctl_ff.valid) begin
         acc_re_in = base_re + t_re;
         acc_im_in = base_im + t_im;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pctl_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         pctl_ff <= op_ctrl;
         done_ff <= pctl_ff.valid & pctl_ff.last;
      end
      p_rr_ff   <= p_rr_in;
      p_ii_ff   <= p_ii_in;
      p_ri_ff   <= p_ri_in;
      p_ir_ff   <= p_ir_in;
      acc_re_ff <= acc_re_in;
      acc_im_ff <= acc_im_in;
   end

   assign acc_re = acc_re_ff;
   assign acc_im = acc_im_ff;
   assign done   = done_ff;

endmodule

// ----- rtl/core/complex_strided_window_correlator_unit.sv -----
// Top level of the complex strided window correlator: stores, sequencer and result register.
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_ready   req_type, req_coef_index, req_data_*, req_last_sample
//   rsp      out        rsp_valid/rsp_ready   rsp_sum_real, rsp_sum_imag, rsp_final_window
//   csr      in         csr_we                csr_index, csr_wdata
//
// A coefficient load or a sample that gives no result leaves the unit in its idle state.
// A sample that gives a result runs one complex MAC over the window one tap per cycle,
// behind a registered store read and a product stage.
// Reset clears the stream state and sets tap_count and stride to one; no clearing pass.
// A result waiting in the output register holds the next finished window, with req_ready
// low, until rsp_ready frees the register.
module complex_strided_window_correlator_unit #(
   parameter int MAX_TAPS    = 64,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_type,
   input  logic [cswc_pkg::COEF_IDX_W-1:0]       req_coef_index,
   input  logic signed [SAMPLE_BITS-1:0]         req_data_real,
   input  logic signed [SAMPLE_BITS-1:0]         req_data_imag,
   input  logic                                  req_last_sample,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [cswc_pkg::ACC_W-1:0]     rsp_sum_real,
   output logic signed [cswc_pkg::ACC_W-1:0]     rsp_sum_imag,
   output logic                                  rsp_final_window,
   input  logic                                  csr_we,
   input  logic [cswc_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [cswc_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   localparam int ADDR_W = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
   localparam int CNT_W  = $clog2(MAX_TAPS + 1);
   localparam int LIM_W  = (CNT_W > cswc_pkg::TAP_CNT_W) ? CNT_W : cswc_pkg::TAP_CNT_W;
   localparam int WORD_W = 2 * SAMPLE_BITS;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN,
      ST_PUBLISH
   } state_type;

   state_type                          state_ff, state_in;
   logic [cswc_pkg::TAP_CNT_W-1:0]     tap_count_ff, tap_count_in;
   logic [cswc_pkg::STRIDE_W-1:0]      stride_ff, stride_in;
   logic [CNT_W-1:0]                   fill_ff, fill_in;
   logic [cswc_pkg::STRIDE_W-1:0]      phase_ff, phase_in;
   logic [ADDR_W-1:0]                  wr_ptr_ff, wr_ptr_in;
   logic [ADDR_W-1:0]                  samp_addr_ff, samp_addr_in;
   logic [ADDR_W-1:0]                  coef_addr_ff, coef_addr_in;
   logic [ADDR_W-1:0]                  taps_m1_ff, taps_m1_in;
   logic                               final_ff, final_in;
   cswc_pkg::mac_ctrl_type             rd_ctrl_ff, rd_ctrl_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic signed [cswc_pkg::ACC_W-1:0]  sum_re_ff, sum_re_in, sum_im_ff, sum_im_in;
   logic                               rsp_final_ff, rsp_final_in;

   logic [WORD_W-1:0]                  coef_mem [MAX_TAPS];
   logic [WORD_W-1:0]                  samp_mem [MAX_TAPS];
   logic [WORD_W-1:0]                  coef_rd_ff, samp_rd_ff;

   logic                               req_fire, slot_free, coef_ok, coef_we, samp_we;
   logic                               full, emit, mac_done;
   logic [CNT_W-1:0]                   eff_taps, fill_new;
   logic [LIM_W-1:0]                   tap_ext;
   logic [ADDR_W-1:0]                  newest, eff_m1, start_addr;
   logic [cswc_pkg::STRIDE_W-1:0]      st_eff, p0;
   logic signed [cswc_pkg::ACC_W-1:0]  acc_re, acc_im;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid & req_ready;
   assign slot_free = ~rsp_valid_ff | rsp_ready;

   always_comb begin
      tap_ext = LIM_W'(tap_count_ff);
      if (tap_count_ff == '0) begin
         eff_taps = CNT_W'(1);
      end else if (tap_ext > LIM_W'(MAX_TAPS)) begin
         eff_taps = CNT_W'(MAX_TAPS);
      end else begin
         eff_taps = CNT_W'(tap_ext);
      end
      eff_m1 = ADDR_W'(eff_taps - CNT_W'(1));

      newest = (wr_ptr_ff == ADDR_W'(MAX_TAPS - 1)) ? '0 : wr_ptr_ff + ADDR_W'(1);
      if (newest >= eff_m1) begin
         start_addr = newest - eff_m1;
      end else begin
         start_addr = ADDR_W'((ADDR_W + 1)'(newest) + (ADDR_W + 1)'(MAX_TAPS)
                              - (ADDR_W + 1)'(eff_m1));
      end

      fill_new = (fill_ff < CNT_W'(MAX_TAPS)) ? fill_ff + CNT_W'(1) : fill_ff;
      full     = (fill_new >= eff_taps);
      st_eff   = (stride_ff == '0) ? cswc_pkg::STRIDE_W'(1) : stride_ff;
      p0       = (phase_ff >= st_eff) ? '0 : phase_ff;
      emit     = full & (req_last_sample | (p0 == '0));

      coef_ok = (LIM_W'(req_coef_index) < LIM_W'(MAX_TAPS));
      coef_we = req_fire & (req_type == cswc_pkg::REQ_COEF) & coef_ok;
      samp_we = req_fire & (req_type == cswc_pkg::REQ_SAMPLE);
   end

   always_comb begin
      state_in     = state_ff;
      tap_count_in = tap_count_ff;
      stride_in    = stride_ff;
      fill_in      = fill_ff;
      phase_in     = phase_ff;
      wr_ptr_in    = wr_ptr_ff;
      samp_addr_in = samp_addr_ff;
      coef_addr_in = coef_addr_ff;
      taps_m1_in   = taps_m1_ff;
      final_in     = final_ff;
      rd_ctrl_in   = '0;
      sum_re_in    = sum_re_ff;
      sum_im_in    = sum_im_ff;
      rsp_final_in = rsp_final_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;

      if (csr_we) begin
         unique case (csr_index)
            cswc_pkg::CSR_TAP_COUNT: tap_count_in = csr_wdata[cswc_pkg::TAP_CNT_W-1:0];
            cswc_pkg::CSR_STRIDE:    stride_in    = csr_wdata[cswc_pkg::STRIDE_W-1:0];
            default:                 ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (samp_we) begin
               wr_ptr_in = newest;
               fill_in   = fill_new;
               if (full) begin
                  phase_in = (p0 == st_eff - cswc_pkg::STRIDE_W'(1)) ? '0
                             : p0 + cswc_pkg::STRIDE_W'(1);
               end
               if (req_last_sample) begin
                  fill_in  = '0;
                  phase_in = '0;
               end
               if (emit) begin
                  state_in     = ST_RUN;
                  samp_addr_in = start_addr;
                  coef_addr_in = '0;
                  taps_m1_in   = eff_m1;
                  final_in     = req_last_sample;
               end
            end
         end
         ST_RUN: begin
            rd_ctrl_in.valid = 1'b1;
            rd_ctrl_in.first = (coef_addr_ff == '0);
            rd_ctrl_in.last  = (coef_addr_ff == taps_m1_ff);
            samp_addr_in = (samp_addr_ff == ADDR_W'(MAX_TAPS - 1)) ? '0
                           : samp_addr_ff + ADDR_W'(1);
            coef_addr_in = coef_addr_ff + ADDR_W'(1);
            if (coef_addr_ff == taps_m1_ff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (mac_done) begin
               state_in = ST_PUBLISH;
               if (slot_free) begin
                  state_in     = ST_IDLE;
                  rsp_valid_in = 1'b1;
                  sum_re_in    = acc_re;
                  sum_im_in    = acc_im;
                  rsp_final_in = final_ff;
               end
            end
         end
         ST_PUBLISH: begin
            if (slot_free) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               sum_re_in    = acc_re;
               sum_im_in    = acc_im;
               rsp_final_in = final_ff;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tap_count_ff <= cswc_pkg::TAP_CNT_W'(1);
         stride_ff    <= cswc_pkg::STRIDE_W'(1);
         fill_ff      <= '0;
         phase_ff     <= '0;
         wr_ptr_ff    <= '0;
         rd_ctrl_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tap_count_ff <= tap_count_in;
         stride_ff    <= stride_in;
         fill_ff      <= fill_in;
         phase_ff     <= phase_in;
         wr_ptr_ff    <= wr_ptr_in;
         rd_ctrl_ff   <= rd_ctrl_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      samp_addr_ff <= samp_addr_in;
      coef_addr_ff <= coef_addr_in;
      taps_m1_ff   <= taps_m1_in;
      final_ff     <= final_in;
      sum_re_ff    <= sum_re_in;
      sum_im_ff    <= sum_im_in;
      rsp_final_ff <= rsp_final_in;
   end

   always_ff @(posedge clock) begin
      if (coef_we) begin
         coef_mem[ADDR_W'(req_coef_index)] <= {req_data_real, req_data_imag};
      end
      coef_rd_ff <= coef_mem[coef_addr_ff];
   end

   always_ff @(posedge clock) begin
      if (samp_we) begin
         samp_mem[newest] <= {req_data_real, req_data_imag};
      end
      samp_rd_ff <= samp_mem[samp_addr_ff];
   end

   cswc_cmac #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_cmac (
      .clock      (clock),
      .reset      (reset),
      .op_ctrl    (rd_ctrl_ff),
      .op_samp_re (samp_rd_ff[WORD_W-1:SAMPLE_BITS]),
      .op_samp_im (samp_rd_ff[SAMPLE_BITS-1:0]),
      .op_coef_re (coef_rd_ff[WORD_W-1:SAMPLE_BITS]),
      .op_coef_im (coef_rd_ff[SAMPLE_BITS-1:0]),
      .acc_re     (acc_re),
      .acc_im     (acc_im),
      .done       (mac_done)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sum_real     = sum_re_ff;
   assign rsp_sum_imag     = sum_im_ff;
   assign rsp_final_window = rsp_final_ff;

   a_done_in_drain: assert property (@(posedge clock) disable iff (reset)
      mac_done |-> state_ff == ST_DRAIN)
      else $error("MAC completion outside drain");

   a_fill_bounded: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_W'(MAX_TAPS))
      else $error("fill count beyond store depth");

   a_emit_busy: assert property (@(posedge clock) disable iff (reset)
      (samp_we && emit) |=> !req_ready)
      else $error("ready while a window is in progress");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_DRAIN || $past(state_ff) == ST_PUBLISH))
      else $error("result raised without a finished window");

endmodule
